### sv/blps_pkg.sv
// ----------------------------------------------------------------------------
// Bucketed linear-probe set package
// Shared types, codes and default sizes for the set unit and its submodules.
// ----------------------------------------------------------------------------
package blps_pkg;

  localparam int SLOTS_PER_BUCKET_DEF = 8;
  localparam int MAX_BUCKETS_DEF      = 1024;
  localparam int PROBE_LIMIT_DEF      = 32;

  localparam int VALUE_BITS = 32;
  localparam int KEY_BITS   = 24;
  localparam int CFG_BITS   = 11;
  localparam int COUNT_BITS = 14;
  localparam int REQ_BITS   = 32;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [2:0] OC_ADDED = 3'd0;
  localparam logic [2:0] OC_FOUND = 3'd1;
  localparam logic [2:0] OC_ZERO  = 3'd2;
  localparam logic [2:0] OC_EMPTY = 3'd3;
  localparam logic [2:0] OC_LIMIT = 3'd4;

  typedef struct packed {
    logic                  opcode;
    logic [KEY_BITS-1:0]   bucket_key;
    logic [VALUE_BITS-1:0] element_value;
  } req_t;

  typedef struct packed {
    logic                  success;
    logic [2:0]            outcome;
    logic [COUNT_BITS-1:0] stored_count;
    logic [REQ_BITS-1:0]   request_count;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic rd_en;
    logic probe_next;
    logic commit;
    logic clear_step;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic skip;
    logic chk_done;
    logic result_ready;
  } dp_stat_t;

endpackage

### sv/blps_datapath.sv
// ----------------------------------------------------------------------------
// Set datapath
// Bucket memory, key reduction unit, probe decision logic, counters and
// the result register.
// ----------------------------------------------------------------------------
module blps_datapath #(
  parameter int SLOTS_PER_BUCKET = 8,
  parameter int MAX_BUCKETS      = 1024,
  parameter int PROBE_LIMIT      = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  blps_pkg::req_t                   req,
  input  logic                             cfg_we,
  input  logic [blps_pkg::CFG_BITS-1:0]    cfg_data,
  input  blps_pkg::ctl_cmd_t               cmd,
  output blps_pkg::dp_stat_t               stat,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output blps_pkg::rsp_t                   rsp
);
  import blps_pkg::*;

  localparam int NPROBE   = PROBE_LIMIT / SLOTS_PER_BUCKET;
  localparam int PW       = $clog2(NPROBE + 1);
  localparam int BW       = $clog2(MAX_BUCKETS);
  localparam int NBW      = $clog2(MAX_BUCKETS + 1);
  localparam int SW       = $clog2(SLOTS_PER_BUCKET);
  localparam int SIW      = (SW > 0) ? SW : 1;
  localparam int ROW_BITS = SLOTS_PER_BUCKET * VALUE_BITS;
  localparam int LAST_P   = (NPROBE > 0) ? NPROBE - 1 : 0;

  logic [ROW_BITS-1:0]   mem [MAX_BUCKETS];
  logic [ROW_BITS-1:0]   rd_data;
  logic [ROW_BITS-1:0]   wr_data;
  logic [BW-1:0]         wr_addr;
  logic                  wr_en;

  logic [NBW-1:0]        nb;
  logic [NBW-1:0]        nb_next;
  logic [31:0]           cfg_wide;
  logic [BW-1:0]         clr_addr;
  logic                  op;
  logic [VALUE_BITS-1:0] val;
  logic [KEY_BITS-1:0]   key_sh;
  logic [NBW-1:0]        rem;
  logic [NBW:0]          rem_try;
  logic [NBW-1:0]        rem_new;
  logic [BW-1:0]         bucket;
  logic [NBW-1:0]        bucket_inc;
  logic [PW-1:0]         probe_cnt;

  logic [SLOTS_PER_BUCKET-1:0] emp;
  logic [SLOTS_PER_BUCKET-1:0] eq;
  logic                  hit_any;
  logic                  hit_emp;
  logic [SIW-1:0]        hit_idx;
  logic [2:0]            oc;
  logic                  chk_done;
  logic                  add;
  logic                  bump;

  logic [COUNT_BITS-1:0] stored_total;
  logic [COUNT_BITS-1:0] stored_total_next;
  logic [REQ_BITS-1:0]   insert_requests;
  logic [REQ_BITS-1:0]   insert_requests_next;

  always_comb begin
    cfg_wide = 32'(cfg_data);
    if (cfg_wide == 32'd0) begin
      nb_next = NBW'(1);
    end else if (cfg_wide > 32'(MAX_BUCKETS)) begin
      nb_next = NBW'(MAX_BUCKETS);
    end else begin
      nb_next = NBW'(cfg_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nb <= NBW'(MAX_BUCKETS);
    end else if (cfg_we) begin
      nb <= nb_next;
    end
  end

  always_comb begin
    rem_try = {rem, key_sh[KEY_BITS-1]};
    if (rem_try >= {1'b0, nb}) begin
      rem_try = rem_try - {1'b0, nb};
    end
    rem_new = NBW'(rem_try);
    bucket_inc = NBW'(bucket) + NBW'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op     <= req.opcode;
      val    <= req.element_value[VALUE_BITS-1:0];
      key_sh <= req.bucket_key;
      rem    <= '0;
    end else if (cmd.div_step) begin
      key_sh <= {key_sh[KEY_BITS-2:0], 1'b0};
      rem    <= rem_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step) begin
      bucket    <= BW'(rem_new);
      probe_cnt <= '0;
    end else if (cmd.probe_next) begin
      bucket    <= (bucket_inc == nb) ? '0 : BW'(bucket_inc);
      probe_cnt <= probe_cnt + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + BW'(1);
    end
  end

  always_comb begin
    hit_any = 1'b0;
    hit_emp = 1'b0;
    hit_idx = '0;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      emp[s] = (rd_data[s*VALUE_BITS +: VALUE_BITS] == '0);
      eq[s]  = (rd_data[s*VALUE_BITS +: VALUE_BITS] == val);
    end
    for (int s = SLOTS_PER_BUCKET - 1; s >= 0; s--) begin
      if (emp[s] || eq[s]) begin
        hit_any = 1'b1;
        hit_emp = emp[s];
        hit_idx = SIW'(s);
      end
    end
  end

  always_comb begin
    if (val == '0) begin
      oc       = OC_ZERO;
      chk_done = 1'b1;
    end else if (NPROBE == 0) begin
      oc       = OC_LIMIT;
      chk_done = 1'b1;
    end else if (op == OP_INSERT) begin
      if (hit_any) begin
        oc       = hit_emp ? OC_ADDED : OC_FOUND;
        chk_done = 1'b1;
      end else begin
        oc       = OC_LIMIT;
        chk_done = (probe_cnt == PW'(LAST_P));
      end
    end else begin
      if (emp[0]) begin
        oc       = OC_EMPTY;
        chk_done = 1'b1;
      end else if (|eq) begin
        oc       = OC_FOUND;
        chk_done = 1'b1;
      end else begin
        oc       = OC_LIMIT;
        chk_done = (probe_cnt == PW'(LAST_P));
      end
    end
  end

  assign add  = cmd.commit && (op == OP_INSERT) && (oc == OC_ADDED);
  assign bump = cmd.commit && (op == OP_INSERT) && (oc != OC_FOUND);

  always_comb begin
    stored_total_next    = add ? stored_total + COUNT_BITS'(1) : stored_total;
    insert_requests_next = insert_requests;
    if (bump && (insert_requests != '1)) begin
      insert_requests_next = insert_requests + REQ_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stored_total    <= '0;
      insert_requests <= '0;
    end else begin
      stored_total    <= stored_total_next;
      insert_requests <= insert_requests_next;
    end
  end

  always_comb begin
    wr_en   = cmd.clear_step || add;
    wr_addr = cmd.clear_step ? clr_addr : bucket;
    for (int s = 0; s < SLOTS_PER_BUCKET; s++) begin
      if (cmd.clear_step) begin
        wr_data[s*VALUE_BITS +: VALUE_BITS] = '0;
      end else if (SIW'(s) == hit_idx) begin
        wr_data[s*VALUE_BITS +: VALUE_BITS] = val;
      end else begin
        wr_data[s*VALUE_BITS +: VALUE_BITS] = rd_data[s*VALUE_BITS +: VALUE_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      rsp.success       <= (oc == OC_ADDED) || (oc == OC_FOUND);
      rsp.outcome       <= oc;
      rsp.stored_count  <= stored_total_next;
      rsp.request_count <= insert_requests_next;
    end
  end

  assign stat.clear_last   = (clr_addr == BW'(MAX_BUCKETS - 1));
  assign stat.skip         = (val == '0) || (NPROBE == 0);
  assign stat.chk_done     = chk_done;
  assign stat.result_ready = !rsp_valid || !rsp_stall;

  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> !(rsp_valid && rsp_stall))
    else $error("result overwritten while held");

  a_count_stable: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(stored_total))
    else $error("stored count moved without a commit");

  a_write_is_insert: assert property (@(posedge clk) disable iff (rst)
    (wr_en && !cmd.clear_step) |-> (op == OP_INSERT))
    else $error("memory written by a lookup");

endmodule

### sv/blps_controller.sv
// ----------------------------------------------------------------------------
// Set controller
// Sequences the clearing pass, key reduction, bucket reads and result commit.
// ----------------------------------------------------------------------------
module blps_controller (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  blps_pkg::dp_stat_t  stat,
  output blps_pkg::ctl_cmd_t  cmd
);
  import blps_pkg::*;

  localparam int DW = $clog2(KEY_BITS);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [DW-1:0] div_cnt;
  logic [DW-1:0] div_cnt_next;

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid) begin
          cmd.load     = 1'b1;
          div_cnt_next = '0;
          state_next   = S_MOD;
        end
      end
      S_MOD: begin
        if (stat.skip) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          if (div_cnt == DW'(KEY_BITS - 1)) begin
            state_next = S_RD;
          end else begin
            div_cnt_next = div_cnt + DW'(1);
          end
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (stat.chk_done) begin
          if (stat.result_ready) begin
            cmd.commit = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cmd.probe_next = 1'b1;
          state_next     = S_RD;
        end
      end
      S_FIN: begin
        if (stat.result_ready) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  assign req_stall = (state != S_IDLE);

  a_commit_state: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (state == S_CHK || state == S_FIN))
    else $error("commit outside a finishing state");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |=> (state == S_MOD || state == S_RD))
    else $error("reduction step left the reduction sequence");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (state == S_IDLE && !req_stall))
    else $error("request loaded while stalled");

endmodule

### sv/bucketed_linear_probe_set_unit.sv
// ----------------------------------------------------------------------------
// Bucketed linear-probe set unit
// Keeps a set of nonzero values in a bucketed slot memory, one bucket per row.
//
// The request channel (req_valid, req_stall, req) carries an insert or a
// lookup; a transaction completes when req_valid is high and req_stall low.
// One response transaction (rsp_valid, rsp_stall, rsp) follows each request.
// The bucket count is written through cfg_valid, cfg_ready and cfg_data.
// One request is worked on at a time. The key is reduced modulo the bucket
// count by a one-bit-per-cycle remainder unit; then each bucket is read in
// S_RD and checked in S_CHK on the single memory read port. At most 4
// buckets are probed with default sizes, and a new request is taken only
// after the current one has committed its result.
// Zero values skip the memory and go from S_MOD straight to S_FIN.
// After reset all MAX_BUCKETS rows of the memory are cleared, one row per
// cycle, while req_stall is held high. A stalled response is held in its
// register, and the next request may be taken and worked on meanwhile.
// ----------------------------------------------------------------------------
module bucketed_linear_probe_set_unit #(
  parameter int SLOTS_PER_BUCKET = blps_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int MAX_BUCKETS      = blps_pkg::MAX_BUCKETS_DEF,
  parameter int PROBE_LIMIT      = blps_pkg::PROBE_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  blps_pkg::req_t                req,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output blps_pkg::rsp_t                rsp,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [blps_pkg::CFG_BITS-1:0] cfg_data
);
  import blps_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  blps_controller u_ctl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  blps_datapath #(
    .SLOTS_PER_BUCKET (SLOTS_PER_BUCKET),
    .MAX_BUCKETS      (MAX_BUCKETS),
    .PROBE_LIMIT      (PROBE_LIMIT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule

### test/tb_bucketed_linear_probe_set_unit.sv
// ----------------------------------------------------------------------------
// Testbench for the bucketed linear-probe set unit
// Runs a short directed table and then random inserts and lookups under
// several bucket counts. Responses are checked field by field, in order,
// against typed table rows or a behavioural model. Idle and stall bursts are
// applied on both channels. A long response hold-off makes the unit back up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bucketed_linear_probe_set_unit;
  import blps_pkg::*;

  localparam int SPB        = SLOTS_PER_BUCKET_DEF;
  localparam int NBUCKETS   = MAX_BUCKETS_DEF;
  localparam int NSLOTS     = NBUCKETS * SPB;
  localparam int INS_PROBES = (PROBE_LIMIT_DEF / SPB) * SPB;
  localparam int LKP_BKTS   = PROBE_LIMIT_DEF / SPB;
  localparam int WATCHDOG   = 5000;
  localparam int HOLD_LEN   = 300;
  localparam int POOL_SIZE  = 64;

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } row_t;

  logic                clk;
  logic                rst;
  logic                req_valid;
  logic                req_stall;
  req_t                req;
  logic                rsp_valid;
  logic                rsp_stall;
  rsp_t                rsp;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_BITS-1:0] cfg_data;

  logic [VALUE_BITS-1:0] model_slots [NSLOTS];
  logic [COUNT_BITS-1:0] model_stored;
  logic [REQ_BITS-1:0]   model_requests;
  logic [CFG_BITS-1:0]   model_buckets;

  rsp_t pending_rsp [$];
  row_t directed [$];
  logic [VALUE_BITS-1:0] pool_val [POOL_SIZE];
  logic [KEY_BITS-1:0]   pool_key [POOL_SIZE];

  int  mismatches;
  int  idle_cycles;
  int  sent_items;
  int  got_rsps;
  bit  idle_on;
  bit  long_hold;
  int  oc_seen [5];

  bucketed_linear_probe_set_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic rsp_t apply_to_set(req_t r);
    rsp_t o;
    int   nb;
    int   idx;
    int   n;
    logic [2:0] oc;
    bit   done;
    nb = (model_buckets == 0) ? 1 : (model_buckets > NBUCKETS) ? NBUCKETS : model_buckets;
    idx = (r.bucket_key % nb) * SPB;
    done = 1'b0;
    if (r.element_value == 0) begin
      if (r.opcode == OP_INSERT && model_requests != '1) model_requests++;
      oc = OC_ZERO;
    end else if (r.opcode == OP_INSERT) begin
      oc = OC_LIMIT;
      for (n = 0; n < INS_PROBES && !done; n++) begin
        if (model_slots[idx] == 0) begin
          model_slots[idx] = r.element_value;
          model_stored++;
          oc = OC_ADDED;
          done = 1'b1;
        end else if (model_slots[idx] == r.element_value) begin
          oc = OC_FOUND;
          done = 1'b1;
        end else begin
          idx = (idx + 1 >= nb * SPB) ? 0 : idx + 1;
        end
      end
      if (oc != OC_FOUND && model_requests != '1) model_requests++;
    end else begin
      oc = OC_LIMIT;
      for (n = 0; n < LKP_BKTS && !done; n++) begin
        if (model_slots[idx] == 0) begin
          oc = OC_EMPTY;
          done = 1'b1;
        end else begin
          for (int s = 0; s < SPB; s++)
            if (model_slots[idx + s] == r.element_value) done = 1'b1;
          if (done) oc = OC_FOUND;
          idx = (idx + SPB >= nb * SPB) ? 0 : idx + SPB;
        end
      end
    end
    o.success       = (oc == OC_ADDED || oc == OC_FOUND);
    o.outcome       = oc;
    o.stored_count  = model_stored;
    o.request_count = model_requests;
    return o;
  endfunction

  task automatic add_row(logic op, int key, logic [31:0] v, bit typed,
                         logic [2:0] oc, int cnt, int reqs);
    row_t w;
    w.r.opcode = op;
    w.r.bucket_key = KEY_BITS'(key);
    w.r.element_value = v;
    w.typed = typed;
    w.want.success = (oc == OC_ADDED || oc == OC_FOUND);
    w.want.outcome = oc;
    w.want.stored_count = COUNT_BITS'(cnt);
    w.want.request_count = REQ_BITS'(reqs);
    directed.push_back(w);
  endtask

  task automatic send_item(req_t r, bit typed, rsp_t want);
    rsp_t p;
    req <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    p = apply_to_set(r);
    pending_rsp.push_back(typed ? want : p);
    sent_items++;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending_rsp.size() != 0) @(negedge clk);
  endtask

  task automatic write_bucket_count(logic [CFG_BITS-1:0] v);
    drain_responses();
    repeat (40) @(negedge clk);
    cfg_data <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    model_buckets = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic req_t random_item();
    req_t r;
    int   i;
    i = $urandom_range(0, POOL_SIZE - 1);
    r.opcode = 1'($urandom_range(0, 1));
    r.bucket_key = pool_key[i];
    r.element_value = pool_val[i];
    case ($urandom_range(0, 15))
      0: r.element_value = '0;
      1, 2, 3: r.element_value = $urandom;
      4: r.bucket_key = KEY_BITS'($urandom);
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("Watchdog expired with %0d responses outstanding", pending_rsp.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  always @(posedge clk) begin
    rsp_t w;
    if (!rst && rsp_valid && !rsp_stall) begin
      got_rsps++;
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected response transaction %p", rsp);
      end else begin
        w = pending_rsp.pop_front();
        if (rsp.outcome < 5) oc_seen[rsp.outcome]++;
        if (rsp.success !== w.success || rsp.outcome !== w.outcome ||
            rsp.stored_count !== w.stored_count || rsp.request_count !== w.request_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch at response %0d: expected %p, got %p", got_rsps, w, rsp);
        end
      end
    end
  end

  initial begin
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
        long_hold = 1'b0;
        rsp_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        rsp_stall <= 1'b1;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [CFG_BITS-1:0] phase_cfg [8];
    rsp_t none;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    sent_items = 0;
    got_rsps = 0;
    idle_on = 1'b1;
    long_hold = 1'b0;
    none = '0;
    foreach (model_slots[i]) model_slots[i] = '0;
    model_stored = '0;
    model_requests = '0;
    model_buckets = CFG_BITS'(NBUCKETS);
    foreach (pool_val[i]) begin
      pool_val[i] = $urandom;
      pool_key[i] = KEY_BITS'($urandom);
    end
    phase_cfg = '{11'd1, 11'd0, 11'd2047, 11'd3, 11'd1024, 11'd16, 11'd1000, 11'd2};

    add_row(OP_LOOKUP, 0, 32'd5, 1'b1, OC_EMPTY, 0, 0);
    add_row(OP_INSERT, 0, 32'd0, 1'b1, OC_ZERO, 0, 1);
    add_row(OP_LOOKUP, 3, 32'd0, 1'b1, OC_ZERO, 0, 1);
    add_row(OP_INSERT, 0, 32'hFFFF_FFFF, 1'b1, OC_ADDED, 1, 2);
    add_row(OP_INSERT, 1024, 32'hFFFF_FFFF, 1'b1, OC_FOUND, 1, 2);
    add_row(OP_LOOKUP, 0, 32'hFFFF_FFFF, 1'b1, OC_FOUND, 1, 2);
    add_row(OP_INSERT, 24'hFF_FFFF, 32'd1, 1'b1, OC_ADDED, 2, 3);
    add_row(OP_LOOKUP, 24'hFF_FFFF, 32'd2, 1'b0, OC_EMPTY, 0, 0);
    add_row(OP_INSERT, 1023, 32'd2, 1'b0, OC_ADDED, 0, 0);
    for (int i = 0; i < 9; i++) add_row(OP_INSERT, 5, 32'd10 + i, 1'b0, OC_ADDED, 0, 0);
    add_row(OP_LOOKUP, 5, 32'd18, 1'b0, OC_FOUND, 0, 0);
    add_row(OP_LOOKUP, 5, 32'd99, 1'b0, OC_EMPTY, 0, 0);
    add_row(OP_LOOKUP, 24'hAA_AAAA, 32'h5555_5555, 1'b0, OC_EMPTY, 0, 0);

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    write_bucket_count(11'd1024);
    foreach (directed[i]) send_item(directed[i].r, directed[i].typed, directed[i].want);

    for (int ph = 0; ph < 8; ph++) begin
      write_bucket_count(phase_cfg[ph]);
      idle_on = (ph < 7);
      for (int n = 0; n < 200; n++) begin
        if (ph == 2 && n == 50) long_hold = 1'b1;
        if (ph == 3 && n == 100) drain_responses();
        send_item(random_item(), 1'b0, none);
      end
    end

    drain_responses();
    repeat (60) @(negedge clk);
    $display("Sent %0d requests over 8 bucket counts; %0d responses checked.",
             sent_items, got_rsps);
    $display("Outcomes added/found/zero/empty/limit: %0d/%0d/%0d/%0d/%0d, mismatches %0d",
             oc_seen[0], oc_seen[1], oc_seen[2], oc_seen[3], oc_seen[4], mismatches);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
